// ===== hw/rtl/jls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jls_pkg
// Shared types and constants of the Jacobi linear solver: beat formats,
// opcodes, status codes, configuration register indexes and queue commands.
// ----------------------------------------------------------------------------
package jls_pkg;

	localparam int MAX_SIZE = 16;
	localparam int IDX_W    = 4;
	localparam int DIM_W    = 5;
	localparam int VAL_W    = 32;
	localparam int CNT_W    = 16;
	localparam int MADDR_W  = 2 * IDX_W;
	localparam int MDEPTH   = MAX_SIZE * MAX_SIZE;

	// Input opcodes.
	localparam logic [2:0] OP_SET_A = 3'd0;
	localparam logic [2:0] OP_ADD_A = 3'd1;
	localparam logic [2:0] OP_SET_R = 3'd2;
	localparam logic [2:0] OP_SET_X = 3'd3;
	localparam logic [2:0] OP_SOLVE = 3'd4;

	// Result status codes.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_RANGE  = 2'd1;
	localparam logic [1:0] ST_CONV   = 2'd2;
	localparam logic [1:0] ST_NOCONV = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] CFG_SIZE  = 2'd0;
	localparam logic [1:0] CFG_TOL   = 2'd1;
	localparam logic [1:0] CFG_MAXIT = 2'd2;

	typedef enum logic [2:0] {
		K_SET_A,
		K_ADD_A,
		K_SET_R,
		K_SET_X,
		K_SOLVE,
		K_REJECT
	} kind_t;

	typedef struct packed {
		logic [2:0]              opcode;
		logic [4:0]              row_index;
		logic [4:0]              col_index;
		logic signed [VAL_W-1:0] entry_value;
	} in_t;

	typedef struct packed {
		logic [1:0]              status;
		logic [IDX_W-1:0]        out_index;
		logic signed [VAL_W-1:0] out_value;
		logic [CNT_W-1:0]        iteration_count;
		logic                    zero_diagonal;
		logic                    last;
	} out_t;

	typedef struct packed {
		kind_t                   kind;
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [VAL_W-1:0] value;
	} cmd_t;

endpackage

// ===== hw/rtl/jls_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jls_front
// Accepts input beats, decodes the opcode, checks indexes against the size
// in use and queues the resulting commands in a two-entry queue.
// ----------------------------------------------------------------------------
module jls_front import jls_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_t              in_data,
	input  logic [DIM_W-1:0] n_eff,
	output logic             cmd_valid,
	input  logic             cmd_ready,
	output cmd_t             cmd
);

	cmd_t       q_mem [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       row_ok;
	logic       col_ok;
	logic       push;
	logic       pop;

	// Classify the incoming beat.
	always_comb begin
		row_ok    = in_data.row_index < n_eff;
		col_ok    = in_data.col_index < n_eff;
		cls.row   = in_data.row_index[IDX_W-1:0];
		cls.col   = in_data.col_index[IDX_W-1:0];
		cls.value = in_data.entry_value;
		unique case (in_data.opcode)
			OP_SET_A: cls.kind = (row_ok && col_ok) ? K_SET_A : K_REJECT;
			OP_ADD_A: cls.kind = (row_ok && col_ok) ? K_ADD_A : K_REJECT;
			OP_SET_R: cls.kind = row_ok ? K_SET_R : K_REJECT;
			OP_SET_X: cls.kind = row_ok ? K_SET_X : K_REJECT;
			OP_SOLVE: cls.kind = K_SOLVE;
			default:  cls.kind = K_REJECT;
		endcase
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = q_mem[rp_q];

	// Queue payload.
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wp_q] <= cls;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== hw/rtl/jls_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jls_back
// Executes queued commands: matrix and vector writes, and the Jacobi solve
// with a pipelined multiply-accumulate, a bit-serial divider and a
// squared-change accumulator. Drives the output register.
// ----------------------------------------------------------------------------
module jls_back import jls_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  cmd_t             cmd,
	input  logic [DIM_W-1:0] n_eff,
	input  logic [31:0]      tol,
	input  logic [CNT_W-1:0] max_it,
	output logic             out_valid,
	input  logic             out_ready,
	output out_t             out_data
);

	localparam int ACC_W = 54;
	localparam int EX_W  = ACC_W + 1;
	localparam int E_W   = 47;
	localparam int Q_W   = E_W + 16;
	localparam logic signed [EX_W-1:0] E_HI = 55'sd70368744177663;
	localparam logic signed [EX_W-1:0] E_LO = -55'sd70368744177664;
	localparam logic signed [64:0] V_HI = 65'sd2147483647;
	localparam logic signed [64:0] V_LO = -65'sd2147483648;

	typedef enum logic [11:0] {
		S_IDLE = 12'b000000000001,
		S_ADD  = 12'b000000000010,
		S_ZRD  = 12'b000000000100,
		S_ZCHK = 12'b000000001000,
		S_MAC  = 12'b000000010000,
		S_RES  = 12'b000000100000,
		S_DIVI = 12'b000001000000,
		S_DIV  = 12'b000010000000,
		S_UPD  = 12'b000100000000,
		S_SQ   = 12'b001000000000,
		S_ACC  = 12'b010000000000,
		S_EMIT = 12'b100000000000
	} state_t;

	state_t state_q;

	// Storage.
	logic signed [VAL_W-1:0] mat_mem [MDEPTH];
	logic [MDEPTH-1:0]       mv_q;
	logic signed [VAL_W-1:0] rhs_q [MAX_SIZE];
	logic signed [VAL_W-1:0] sol_q [2][MAX_SIZE];
	logic                    bank_q;

	// Matrix port.
	logic [MADDR_W-1:0]      ra;
	logic                    mwe;
	logic [MADDR_W-1:0]      wa;
	logic signed [VAL_W-1:0] wd;
	logic signed [VAL_W-1:0] mrd_q;
	logic                    mvld_s1;
	logic signed [VAL_W-1:0] a_s1;

	// Sequencing.
	logic [IDX_W-1:0]  nm1;
	logic [IDX_W-1:0]  i_q;
	logic [IDX_W-1:0]  j_q;
	logic              issued_q;
	logic              issue;
	logic [IDX_W-1:0]  xidx;
	logic [CNT_W-1:0]  it_q;
	logic              zd_q;
	logic              conv_q;

	// Multiply-accumulate pipeline.
	logic                    v_s1, lst_s1, dg_s1;
	logic signed [VAL_W-1:0] xj_s1;
	logic                    v_s2, lst_s2;
	logic signed [63:0]      prod_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [VAL_W-1:0] diag_q;
	logic signed [VAL_W-1:0] prev_i_q;

	// Residual and divider.
	logic signed [EX_W-1:0]  ediff;
	logic signed [E_W-1:0]   e_q;
	logic [E_W-1:0]          e_mag;
	logic [VAL_W-1:0]        den_q;
	logic [Q_W-1:0]          quo_q;
	logic [VAL_W-1:0]        rem_q;
	logic                    neg_q;
	logic [5:0]              dcnt_q;
	logic [VAL_W:0]          dshift;
	logic                    dge;

	// Update and squared change.
	logic signed [63:0]      qv;
	logic signed [64:0]      tdiff;
	logic signed [VAL_W-1:0] xn;
	logic signed [VAL_W:0]   d_q;
	logic [VAL_W:0]          ad;
	logic [63:0]             sq_q;
	logic [63:0]             sum_q;
	logic [64:0]             s65;
	logic [63:0]             sum_n;

	logic                    out_free;
	logic                    out_fire;
	out_t                    load_res;
	out_t                    emit_res;
	logic                    take;
	logic signed [VAL_W:0]   add_w;
	logic signed [VAL_W-1:0] add_sat;
	logic [MADDR_W-1:0]      add_addr_q;
	logic signed [VAL_W-1:0] add_val_q;

	assign nm1      = IDX_W'(n_eff - 5'd1);
	assign out_free = !out_valid || out_ready;
	assign take     = (state_q == S_IDLE) && cmd_valid && out_free;
	assign cmd_ready = take;
	assign issue    = (state_q == S_MAC) && !issued_q;
	assign a_s1     = mvld_s1 ? mrd_q : '0;
	assign xidx     = (state_q == S_EMIT) ? i_q : j_q;
	assign out_fire = (take && cmd.kind != K_SOLVE) || (state_q == S_EMIT && out_free);

	// Result beat formats for loads and for solution entries.
	always_comb begin
		load_res        = '0;
		load_res.last   = 1'b1;
		load_res.status = (cmd.kind == K_REJECT) ? ST_RANGE : ST_OK;
		emit_res                 = '0;
		emit_res.status          = conv_q ? ST_CONV : ST_NOCONV;
		emit_res.out_index       = i_q;
		emit_res.out_value       = sol_q[bank_q][i_q];
		emit_res.iteration_count = it_q;
		emit_res.zero_diagonal   = zd_q;
		emit_res.last            = i_q == nm1;
	end

	// Saturating matrix add.
	always_comb begin
		add_w   = (VAL_W+1)'(a_s1) + (VAL_W+1)'(add_val_q);
		add_sat = add_w[VAL_W:VAL_W-1] == 2'b01 ? {1'b0, {(VAL_W-1){1'b1}}} :
			add_w[VAL_W:VAL_W-1] == 2'b10 ? {1'b1, {(VAL_W-1){1'b0}}} :
			add_w[VAL_W-1:0];
	end

	// Matrix read address and write port selection.
	always_comb begin
		ra  = {cmd.row, cmd.col};
		mwe = 1'b0;
		wa  = {cmd.row, cmd.col};
		wd  = cmd.value;
		if (state_q == S_ZRD) begin
			ra = {i_q, i_q};
		end else if (state_q == S_MAC) begin
			ra = {i_q, j_q};
		end
		if (take && cmd.kind == K_SET_A) begin
			mwe = 1'b1;
		end else if (state_q == S_ADD) begin
			mwe = 1'b1;
			wa  = add_addr_q;
			wd  = add_sat;
		end
	end

	// Matrix memory with registered read.
	always_ff @(posedge clk) begin
		if (mwe) begin
			mat_mem[wa] <= wd;
		end
		mrd_q <= mat_mem[ra];
	end

	// Residual, divider step and update arithmetic.
	always_comb begin
		ediff  = EX_W'(acc_q) - EX_W'(rhs_q[i_q]);
		e_mag  = e_q[E_W-1] ? E_W'(-e_q) : E_W'(e_q);
		dshift = {rem_q, quo_q[Q_W-1]};
		dge    = dshift >= {1'b0, den_q};
		if (diag_q == '0) begin
			if (e_q > 0) begin
				qv = 64'sd2147483647;
			end else if (e_q < 0) begin
				qv = -64'sd2147483648;
			end else begin
				qv = '0;
			end
		end else begin
			qv = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		end
		tdiff = 65'(prev_i_q) - 65'(qv);
		if (tdiff > V_HI) begin
			xn = {1'b0, {(VAL_W-1){1'b1}}};
		end else if (tdiff < V_LO) begin
			xn = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			xn = tdiff[VAL_W-1:0];
		end
		ad    = d_q[VAL_W] ? (VAL_W+1)'(-d_q) : (VAL_W+1)'(d_q);
		s65   = {1'b0, sum_q} + {1'b0, sq_q};
		sum_n = s65[64] ? '1 : s65[63:0];
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		xj_s1   <= sol_q[bank_q][xidx];
		prod_s2 <= a_s1 * xj_s1;
		if (v_s1 && dg_s1) begin
			diag_q   <= a_s1;
			prev_i_q <= xj_s1;
		end
		if (take) begin
			add_addr_q <= {cmd.row, cmd.col};
			add_val_q  <= cmd.value;
		end
		if (state_q == S_RES) begin
			if (ediff > E_HI) begin
				e_q <= E_HI[E_W-1:0];
			end else if (ediff < E_LO) begin
				e_q <= E_LO[E_W-1:0];
			end else begin
				e_q <= ediff[E_W-1:0];
			end
		end
		if (state_q == S_DIVI) begin
			den_q <= diag_q[VAL_W-1] ? VAL_W'(-diag_q) : VAL_W'(diag_q);
			neg_q <= e_q[E_W-1] ^ diag_q[VAL_W-1];
			quo_q <= {e_mag, 16'b0};
			rem_q <= '0;
		end else if (state_q == S_DIV) begin
			rem_q <= dge ? VAL_W'(dshift - {1'b0, den_q}) : dshift[VAL_W-1:0];
			quo_q <= {quo_q[Q_W-2:0], dge};
		end
		if (state_q == S_UPD) begin
			d_q <= (VAL_W+1)'(prev_i_q) - (VAL_W+1)'(xn);
		end
		if (state_q == S_SQ) begin
			sq_q <= ad[VAL_W] ? '1 : ad[VAL_W-1:0] * ad[VAL_W-1:0];
		end
	end

	// Control sequencer, vectors and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			mv_q      <= '0;
			mvld_s1   <= 1'b0;
			bank_q    <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			issued_q  <= 1'b0;
			it_q      <= '0;
			zd_q      <= 1'b0;
			conv_q    <= 1'b0;
			v_s1      <= 1'b0;
			lst_s1    <= 1'b0;
			dg_s1     <= 1'b0;
			v_s2      <= 1'b0;
			lst_s2    <= 1'b0;
			acc_q     <= '0;
			dcnt_q    <= '0;
			sum_q     <= '0;
			out_valid <= 1'b0;
			out_data  <= '0;
			for (int k = 0; k < MAX_SIZE; k++) begin
				rhs_q[k]    <= '0;
				sol_q[0][k] <= '0;
				sol_q[1][k] <= '0;
			end
		end else begin
			mvld_s1 <= mv_q[ra];
			if (mwe) begin
				mv_q[wa] <= 1'b1;
			end

			// Output valid: set by a new beat, cleared when taken.
			if (out_fire) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end

			// Multiply-accumulate pipeline flags.
			v_s1   <= issue;
			lst_s1 <= issue && (j_q == nm1);
			dg_s1  <= j_q == i_q;
			v_s2   <= v_s1;
			lst_s2 <= v_s1 && lst_s1;
			if (v_s2) begin
				acc_q <= acc_q + ACC_W'(prod_s2 >>> 16);
			end
			if (issue) begin
				j_q <= j_q + 1'b1;
				if (j_q == nm1) begin
					issued_q <= 1'b1;
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						if (cmd.kind == K_SOLVE) begin
							i_q     <= '0;
							it_q    <= '0;
							zd_q    <= 1'b0;
							state_q <= S_ZRD;
						end else begin
							out_data <= load_res;
							if (cmd.kind == K_SET_R) begin
								rhs_q[cmd.row] <= cmd.value;
							end
							// A guess entry is kept in both banks.
							if (cmd.kind == K_SET_X) begin
								sol_q[0][cmd.row] <= cmd.value;
								sol_q[1][cmd.row] <= cmd.value;
							end
							if (cmd.kind == K_ADD_A) begin
								state_q <= S_ADD;
							end
						end
					end
				end
				S_ADD: begin
					state_q <= S_IDLE;
				end
				S_ZRD: begin
					state_q <= S_ZCHK;
				end
				S_ZCHK: begin
					if (a_s1 == '0) begin
						zd_q <= 1'b1;
					end
					if (i_q == nm1) begin
						i_q <= '0;
						if (max_it == '0) begin
							conv_q  <= 1'b1;
							state_q <= S_EMIT;
						end else begin
							sum_q    <= '0;
							acc_q    <= '0;
							j_q      <= '0;
							issued_q <= 1'b0;
							state_q  <= S_MAC;
						end
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_ZRD;
					end
				end
				S_MAC: begin
					if (lst_s2) begin
						state_q <= S_RES;
					end
				end
				S_RES: begin
					state_q <= S_DIVI;
				end
				S_DIVI: begin
					dcnt_q  <= 6'(Q_W - 1);
					state_q <= (diag_q == '0) ? S_UPD : S_DIV;
				end
				S_DIV: begin
					dcnt_q <= dcnt_q - 6'd1;
					if (dcnt_q == '0) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					sol_q[~bank_q][i_q] <= xn;
					state_q <= S_SQ;
				end
				S_SQ: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					acc_q    <= '0;
					j_q      <= '0;
					issued_q <= 1'b0;
					if (i_q == nm1) begin
						bank_q <= ~bank_q;
						i_q    <= '0;
						if (sum_n <= {32'b0, tol}) begin
							conv_q  <= 1'b1;
							state_q <= S_EMIT;
						end else if (it_q + 1'b1 == max_it) begin
							it_q    <= it_q + 1'b1;
							conv_q  <= 1'b0;
							state_q <= S_EMIT;
						end else begin
							it_q    <= it_q + 1'b1;
							sum_q   <= '0;
							state_q <= S_MAC;
						end
					end else begin
						sum_q   <= sum_n;
						i_q     <= i_q + 1'b1;
						state_q <= S_MAC;
					end
				end
				S_EMIT: begin
					// Bring the other bank up to date so both hold the solution.
					sol_q[~bank_q][i_q] <= sol_q[bank_q][i_q];
					if (out_free) begin
						out_data <= emit_res;
						if (i_q == nm1) begin
							state_q <= S_IDLE;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/jacobi_linear_solver_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jacobi_linear_solver_core
// Jacobi iterative solver for A x = r in signed Q16.16 with a decoupled
// command front end, a solve engine and the configuration registers.
// ----------------------------------------------------------------------------
// Usage: input beats on in_valid/in_ready load matrix, right-hand side and
// guess entries, or start a solve. Results leave on out_valid/out_ready; a
// load beat gives one result, a solve gives one result per solution entry,
// the final one flagged by last. Configuration is written through cfg_we,
// cfg_index and cfg_data; the user must write it only while the block is
// idle, as the block does not enforce this. A load result passes the front
// queue and the output register; loads sustain one beat per cycle while the
// receiver is ready, but a matrix add also holds the engine in its add state,
// and a two-entry queue lets the front keep accepting meanwhile. A solve
// scans the diagonal, then per pass and row runs the multiply pipeline and
// the one-bit-per-cycle divider (skipped for a zero diagonal), then emits.
// Reset clears the matrix (through per-entry valid bits), both vectors and
// the registers at once; no clearing pass is needed. When the receiver
// stalls, results hold in the output register and the engine waits.
// ----------------------------------------------------------------------------
module jacobi_linear_solver_core import jls_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [DIM_W-1:0] size_q;
	logic [31:0]      tol_q;
	logic [CNT_W-1:0] maxit_q;
	logic [DIM_W-1:0] n_eff;
	logic             cmd_valid;
	logic             cmd_ready;
	cmd_t             cmd;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= DIM_W'(MAX_SIZE);
			tol_q   <= '0;
			maxit_q <= 16'd160;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SIZE:  size_q  <= cfg_data[DIM_W-1:0];
				CFG_TOL:   tol_q   <= cfg_data;
				CFG_MAXIT: maxit_q <= cfg_data[CNT_W-1:0];
				default:   ;
			endcase
		end
	end

	// Clamp the size in use to 1..MAX_SIZE.
	always_comb begin
		if (size_q == '0) begin
			n_eff = DIM_W'(1);
		end else if (size_q > DIM_W'(MAX_SIZE)) begin
			n_eff = DIM_W'(MAX_SIZE);
		end else begin
			n_eff = size_q;
		end
	end

	jls_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.n_eff     (n_eff),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	jls_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.n_eff     (n_eff),
		.tol       (tol_q),
		.max_it    (maxit_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Jacobi linear solver core. A directed table
// covers the load extremes, range errors, unknown opcodes, saturating adds
// and solves on degenerate systems; random phases then load mostly
// diagonally dominant systems with some noise and solve them under changing
// register settings. Every result beat is checked against an in-bench model.
// ----------------------------------------------------------------------------
module tb_top;
	import jls_pkg::*;

	localparam int WATCHDOG_LIMIT = 500000;
	localparam int LONG_HOLD      = 300;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_t         in_data;
	logic        out_valid;
	logic        out_ready;
	out_t        out_data;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	jacobi_linear_solver_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Model state of the solver.
	longint          mdl_a [MDEPTH];
	longint          mdl_r [MAX_SIZE];
	longint          mdl_x [MAX_SIZE];
	logic [4:0]      mdl_size;
	logic [31:0]     mdl_tol;
	logic [15:0]     mdl_maxit;

	out_t            pending_results [$];
	int              mismatches;
	int              idle_cycles;
	bit              hold_request;
	bit              rx_fast;
	bit              tx_fast;

	typedef struct {
		in_t        beat;
		bit         typed;
		logic [1:0] st;
	} row_t;
	row_t            directed [$];

	// Clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int size_in_use();
		if (mdl_size == 0) return 1;
		if (mdl_size > MAX_SIZE) return MAX_SIZE;
		return int'(mdl_size);
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic out_t load_result(logic [1:0] st);
		out_t res;
		res        = '0;
		res.status = st;
		res.last   = 1'b1;
		return res;
	endfunction

	// Jacobi passes on the model state; queues one result per entry in use.
	function automatic void solve_system();
		longint          vmax, vmin, emax, emin;
		longint          prev [MAX_SIZE];
		longint          acc, e, q, d, diag, xn;
		longint unsigned ad, sq, sum;
		int              n;
		int unsigned     it;
		bit              zd;
		bit              conv;
		out_t            res;
		vmax = 64'sd2147483647;
		vmin = -vmax - 1;
		emax = 64'sd70368744177663;
		emin = -emax - 1;
		n    = size_in_use();
		zd   = 1'b0;
		sum  = 0;
		for (int i = 0; i < n; i++)
			if (mdl_a[i * MAX_SIZE + i] == 0) zd = 1'b1;
		for (it = 0; it < mdl_maxit; it++) begin
			prev = mdl_x;
			sum  = 0;
			for (int i = 0; i < n; i++) begin
				acc = 0;
				for (int j = 0; j < n; j++)
					acc += (mdl_a[i * MAX_SIZE + j] * prev[j]) >>> 16;
				e    = clamp(acc - mdl_r[i], emin, emax);
				diag = mdl_a[i * MAX_SIZE + i];
				if (diag == 0)
					q = e > 0 ? vmax : (e < 0 ? vmin : 0);
				else
					q = (e * 65536) / diag;
				xn       = clamp(prev[i] - q, vmin, vmax);
				mdl_x[i] = xn;
				d        = prev[i] - xn;
				ad       = d < 0 ? longint'(-d) : longint'(d);
				sq       = ad >= 64'h1_0000_0000 ? '1 : ad * ad;
				sum      = (sum > ~sq) ? '1 : sum + sq;
			end
			if (sum <= mdl_tol) break;
		end
		conv = sum <= mdl_tol;
		for (int i = 0; i < n; i++) begin
			res                 = '0;
			res.status          = conv ? ST_CONV : ST_NOCONV;
			res.out_index       = i[IDX_W-1:0];
			res.out_value       = mdl_x[i][31:0];
			res.iteration_count = it[15:0];
			res.zero_diagonal   = zd;
			res.last            = (i == n - 1);
			pending_results.push_back(res);
		end
	endfunction

	// Applies one accepted input beat to the model and queues its results.
	function automatic void apply_beat(in_t beat, bit queue_it);
		int         n;
		logic [1:0] st;
		longint     v;
		n  = size_in_use();
		st = ST_RANGE;
		v  = longint'(beat.entry_value);
		if (beat.opcode == OP_SOLVE) begin
			solve_system();
			return;
		end
		if (beat.opcode == OP_SET_A || beat.opcode == OP_ADD_A) begin
			if (beat.row_index < n && beat.col_index < n) begin
				if (beat.opcode == OP_SET_A)
					mdl_a[beat.row_index * MAX_SIZE + beat.col_index] = v;
				else
					mdl_a[beat.row_index * MAX_SIZE + beat.col_index] = clamp(
						mdl_a[beat.row_index * MAX_SIZE + beat.col_index] + v,
						-64'sd2147483648, 64'sd2147483647);
				st = ST_OK;
			end
		end else if (beat.opcode == OP_SET_R || beat.opcode == OP_SET_X) begin
			if (beat.row_index < n) begin
				if (beat.opcode == OP_SET_R) mdl_r[beat.row_index] = v;
				else mdl_x[beat.row_index] = v;
				st = ST_OK;
			end
		end
		if (queue_it) pending_results.push_back(load_result(st));
	endfunction

	function automatic in_t make_beat(logic [2:0] op, int row, int col, logic [31:0] v);
		in_t beat;
		beat.opcode      = op;
		beat.row_index   = row[4:0];
		beat.col_index   = col[4:0];
		beat.entry_value = v;
		return beat;
	endfunction

	function automatic void add_row(logic [2:0] op, int row, int col, logic [31:0] v,
			bit typed, logic [1:0] st);
		row_t entry;
		entry.beat  = make_beat(op, row, col, v);
		entry.typed = typed;
		entry.st    = st;
		directed.push_back(entry);
	endfunction

	// Offers one beat after a random gap and records what it should produce.
	task automatic send_beat(in_t beat, bit typed, logic [1:0] st);
		int gap;
		gap = tx_fast ? 0 : $urandom_range(0, 13);
		if ($urandom_range(0, 19) == 0) tx_fast = ~tx_fast;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= beat;
		do @(posedge clk); while (!(in_valid && in_ready));
		if (typed) begin
			apply_beat(beat, 1'b0);
			pending_results.push_back(load_result(st));
		end else begin
			apply_beat(beat, 1'b1);
		end
	endtask

	// Drives one register write; the caller drops the write enable afterwards.
	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		case (idx)
			CFG_SIZE:  mdl_size  = value[4:0];
			CFG_TOL:   mdl_tol   = value;
			CFG_MAXIT: mdl_maxit = value[15:0];
			default: ;
		endcase
	endtask

	// Lets all results drain so that the block is idle again.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_config(logic [31:0] size, logic [31:0] tol, logic [31:0] maxit);
		wait_idle();
		write_reg(CFG_SIZE, size);
		write_reg(CFG_TOL, tol);
		write_reg(CFG_MAXIT, maxit);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] random_tol();
		case ($urandom_range(0, 3))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 65535);
			default: return $urandom;
		endcase
	endfunction

	// Loads a system for the current size (mostly diagonally dominant), with
	// some noise beats mixed in, and then starts a solve.
	task automatic load_and_solve(bit well_formed);
		int          n;
		logic [31:0] v;
		n = size_in_use();
		for (int i = 0; i < n; i++) begin
			if (well_formed) begin
				v = $urandom_range(2, 8) * 65536 + $urandom_range(0, 65535);
				if ($urandom_range(0, 1)) v = -v;
			end else begin
				v = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom;
			end
			send_beat(make_beat(OP_SET_A, i, i, v), 1'b0, ST_OK);
			for (int j = 0; j < n; j++) begin
				if (j != i && $urandom_range(0, 2) == 0) begin
					v = well_formed ? $urandom_range(0, 65536 / n) - 32768 / n : $urandom;
					send_beat(make_beat($urandom_range(0, 1) ? OP_SET_A : OP_ADD_A, i, j,
						v), 1'b0, ST_OK);
				end
			end
			send_beat(make_beat(OP_SET_R, i, 0, $urandom_range(0, 16 * 65536) - 8 * 65536),
				1'b0, ST_OK);
			if ($urandom_range(0, 1))
				send_beat(make_beat(OP_SET_X, i, 0, well_formed ?
					$urandom_range(0, 4 * 65536) - 2 * 65536 : $urandom), 1'b0, ST_OK);
			// Noise: any load or unknown opcode with fully random fields.
			if ($urandom_range(0, 3) == 0) begin
				v = $urandom_range(0, 6);
				if (v == 4) v = 7;
				send_beat(make_beat(v[2:0], $urandom_range(0, 31), $urandom_range(0, 31),
					$urandom), 1'b0, ST_OK);
			end
		end
		send_beat(make_beat(OP_SOLVE, $urandom_range(0, 31), $urandom_range(0, 31),
			$urandom), 1'b0, ST_OK);
	endtask

	// Result side: random stalls, one long hold on request, field checks.
	initial begin
		int   gap;
		out_t want;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = rx_fast ? 0 : $urandom_range(0, 13);
			if ($urandom_range(0, 19) == 0) rx_fast = ~rx_fast;
			if (hold_request) begin
				gap          = LONG_HOLD;
				hold_request = 1'b0;
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result beat: %p", out_data);
			end else begin
				want = pending_results.pop_front();
				if (out_data !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Result mismatch: expected %p, got %p", want, out_data);
				end
			end
		end
	end

	// Watchdog on cycles without any accepted beat.
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Main sequence.
	initial begin
		int items;
		in_valid     <= 1'b0;
		in_data      <= '0;
		cfg_we       <= 1'b0;
		cfg_index    <= CFG_SIZE;
		cfg_data     <= '0;
		arst_n       = 1'b0;
		mismatches   = 0;
		hold_request = 1'b0;
		rx_fast      = 1'b0;
		tx_fast      = 1'b0;
		mdl_size     = 5'd16;
		mdl_tol      = '0;
		mdl_maxit    = 16'd160;
		foreach (mdl_a[k]) mdl_a[k] = 0;
		foreach (mdl_r[k]) mdl_r[k] = 0;
		foreach (mdl_x[k]) mdl_x[k] = 0;
		repeat (8) @(posedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed table at reset settings: solve of the cleared store, load
		// extremes, saturating adds, range errors and unknown opcodes.
		add_row(OP_SOLVE, 0, 0, 32'd0, 1'b0, ST_OK);
		add_row(OP_SET_A, 0, 0, 32'h7FFF_FFFF, 1'b1, ST_OK);
		add_row(OP_ADD_A, 0, 0, 32'd1, 1'b1, ST_OK);
		add_row(OP_SET_A, 1, 1, 32'h8000_0000, 1'b1, ST_OK);
		add_row(OP_ADD_A, 1, 1, 32'hFFFF_FFFF, 1'b1, ST_OK);
		add_row(OP_SET_A, 15, 15, 32'h0001_0000, 1'b1, ST_OK);
		add_row(OP_SET_A, 16, 0, 32'h1234_5678, 1'b1, ST_RANGE);
		add_row(OP_SET_A, 0, 31, 32'h1234_5678, 1'b1, ST_RANGE);
		add_row(OP_ADD_A, 31, 31, 32'hFFFF_FFFF, 1'b1, ST_RANGE);
		add_row(OP_SET_R, 15, 0, 32'h0001_2345, 1'b1, ST_OK);
		add_row(OP_SET_R, 16, 0, 32'h0001_2345, 1'b1, ST_RANGE);
		add_row(OP_SET_X, 0, 0, 32'hFFFF_0000, 1'b1, ST_OK);
		add_row(OP_SET_X, 31, 31, 32'hFFFF_FFFF, 1'b1, ST_RANGE);
		add_row(3'd5, 0, 0, 32'd0, 1'b1, ST_RANGE);
		add_row(3'd6, 1, 1, 32'h7FFF_FFFF, 1'b1, ST_RANGE);
		add_row(3'd7, 31, 31, 32'hFFFF_FFFF, 1'b1, ST_RANGE);
		add_row(OP_SET_R, 3, 0, 32'h7FFF_FFFF, 1'b1, ST_OK);
		add_row(OP_SET_X, 3, 0, 32'h8000_0000, 1'b1, ST_OK);
		foreach (directed[k])
			send_beat(directed[k].beat, directed[k].typed, directed[k].st);

		// Solve over extremes and zero diagonals with a short pass limit.
		set_config(32'd16, 32'd0, 32'd3);
		send_beat(make_beat(OP_SOLVE, 0, 0, 32'd0), 1'b0, ST_OK);

		// One entry at unit diagonal converges within two passes even with the top limit.
		set_config(32'd1, 32'd0, 32'd65535);
		send_beat(make_beat(OP_SET_A, 0, 0, 32'h0001_0000), 1'b0, ST_OK);
		send_beat(make_beat(OP_SET_R, 0, 0, $urandom), 1'b0, ST_OK);
		send_beat(make_beat(OP_SOLVE, 0, 0, 32'd0), 1'b0, ST_OK);

		// Size zero acts as one, and a zero limit runs no pass.
		set_config(32'd0, 32'hFFFF_FFFF, 32'd0);
		load_and_solve(1'b1);

		// Size above the maximum acts as the maximum: the last row is in range.
		set_config(32'd31, random_tol(), $urandom_range(1, 4));
		send_beat(make_beat(OP_SET_R, 15, 0, 32'h0000_8000), 1'b0, ST_OK);
		send_beat(make_beat(OP_SOLVE, 0, 0, 32'd0), 1'b0, ST_OK);

		// Random phases; one of them holds the result side off for a long time.
		items = 0;
		for (int ph = 0; items < 60; ph++) begin
			int n;
			n = $urandom_range(1, 6);
			set_config(n, random_tol(), $urandom_range(1, 40));
			items += 3 * n + 1;
			if (ph == 1) hold_request = 1'b1;
			load_and_solve($urandom_range(0, 4) != 0);
		end

		wait_idle();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== jacobi_linear_solver_core.f =====
hw/rtl/jls_pkg.sv
hw/rtl/jls_front.sv
hw/rtl/jls_back.sv
hw/rtl/jacobi_linear_solver_core.sv
tb/sv/tb_top.sv
